[design/tkf_pkg.sv]
package tkf_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int EST_W     = 10 + FRAC_BITS;          // signed Q10.F estimate
    localparam int COV_W     = 2 + FRAC_BITS;           // unsigned Q2.F covariance
    localparam int DEN_W     = COV_W + 1;               // P + R
    localparam int QUOT_W    = FRAC_BITS + 1;           // gain, 0 .. ONE
    localparam int NUM_W     = COV_W + FRAC_BITS + 1;   // (P << F) + den/2
    localparam int CNT_W     = $clog2(QUOT_W + 1);
    localparam int DIFF_W    = EST_W + 1;               // measurement minus estimate
    localparam int KB_W      = FRAC_BITS + 2;           // signed multiplier operand B
    localparam int PROD_W    = DIFF_W + KB_W;
    localparam int RND_W     = PROD_W - FRAC_BITS + 1;
    localparam int SUM_W     = RND_W + 1;
    localparam int INT_W     = EST_W - FRAC_BITS + 1;   // truncated integer part

    // Port widths fixed by the interface
    localparam int SMP_W     = 9;
    localparam int OUT_W     = 26;
    localparam int CFG_W     = 18;
    localparam int CFG_IDX_W = 3;
    localparam int JTH_W     = 9;
    localparam int DTH_W     = 9;
    localparam int TTH_W     = 8;
    localparam int DIR_W     = 3;

    localparam logic [QUOT_W-1:0] ONE_Q   = QUOT_W'(1) << FRAC_BITS;
    localparam logic [COV_W-1:0]  COV_ONE = COV_W'(1) << FRAC_BITS;
    localparam logic [COV_W-1:0]  COV_MAX = '1;
    localparam logic [PROD_W-1:0] HALF_P  = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic [COV_W-1:0] MEAS_NOISE_RST =
        COV_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [COV_W-1:0] PROC_NOISE_RST =
        COV_W'(((64'd1 << FRAC_BITS) + 64'd10) / 64'd20);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MEAS_NOISE    = 3'd0,
        REG_PROCESS_NOISE = 3'd1,
        REG_JUMP_THRESH   = 3'd2,
        REG_FWD_THRESH    = 3'd3,
        REG_BWD_THRESH    = 3'd4,
        REG_TURN_THRESH   = 3'd5
    } reg_idx_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_FORWARD  = 3'd0,
        DIR_BACKWARD = 3'd1,
        DIR_RIGHT    = 3'd2,
        DIR_LEFT     = 3'd3,
        DIR_STOP     = 3'd4
    } dir_t;

endpackage

[design/tilt_kalman_filter_direction_top.sv]
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | s_sample_x, s_sample_y, s_sample_z
// m_      | out       | m_valid / m_ready  | m_smooth_x/y/z, m_bypassed,
//         |           |                    | m_heading_cmd, m_cmd_changed
// cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wr_data
//
// A filtered word runs PREP, DIV (17-bit gain divide), MUL1, EST and COV per axis, then DIR;
// a bypassed word goes straight to DIR, which loads the output register and raises m_valid once it is free.
// The gain divider is the long pole: one quotient bit per cycle, reused per axis.
// s_ready is high only while the sequencer idles; a finished result sits in the
// output register, so the next word is accepted while m_ready is low.
// Synchronous active-low reset restores estimates, covariances and thresholds.
module tilt_kalman_filter_direction_top import tkf_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration
    input  logic                    cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    // sample input
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [SMP_W-1:0] s_sample_x,
    input  logic signed [SMP_W-1:0] s_sample_y,
    input  logic signed [SMP_W-1:0] s_sample_z,
    // result output
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [OUT_W-1:0] m_smooth_x,
    output logic signed [OUT_W-1:0] m_smooth_y,
    output logic signed [OUT_W-1:0] m_smooth_z,
    output logic                    m_bypassed,
    output logic [DIR_W-1:0]        m_heading_cmd,
    output logic                    m_cmd_changed
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_PREP = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_MUL1 = 7'b0001000,
        ST_EST  = 7'b0010000,
        ST_COV  = 7'b0100000,
        ST_DIR  = 7'b1000000
    } state_t;

    localparam logic signed [SUM_W-1:0] X_MAX = SUM_W'((64'sd1 <<< (EST_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] X_MIN = SUM_W'(-(64'sd1 <<< (EST_W - 1)));
    localparam logic signed [EST_W-1:0] EST_NINE = EST_W'(9) <<< FRAC_BITS;

    // Configuration registers
    logic [COV_W-1:0]        meas_noise_reg;
    logic [COV_W-1:0]        proc_noise_reg;
    logic [JTH_W-1:0]        jump_thr_reg;
    logic signed [DTH_W-1:0] fwd_thr_reg;
    logic signed [DTH_W-1:0] bwd_thr_reg;
    logic [TTH_W-1:0]        turn_thr_reg;

    // Filter state
    logic signed [EST_W-1:0] est_reg      [3];
    logic [COV_W-1:0]        cov_reg      [3];
    logic signed [SMP_W-1:0] prev_raw_reg [3];
    logic signed [SMP_W-1:0] raw_reg      [3];
    logic signed [EST_W-1:0] smooth_reg   [3];
    dir_t                    last_dir_reg;

    // Sequencer
    state_t            state_reg;
    logic [1:0]        axis_reg;
    logic              jump_reg;
    logic [COV_W-1:0]  p_reg;
    logic              den_zero_reg;
    logic [QUOT_W-1:0] k_reg;

    // Output register
    logic                    m_valid_reg;
    logic signed [OUT_W-1:0] out_x_reg;
    logic signed [OUT_W-1:0] out_y_reg;
    logic signed [OUT_W-1:0] out_z_reg;
    logic                    out_byp_reg;
    logic [DIR_W-1:0]        out_dir_reg;
    logic                    out_chg_reg;

    // -------------------------------------------------------------------
    // Jump detect on the incoming word against the previous raw sample
    // -------------------------------------------------------------------
    logic signed [SMP_W-1:0] s_in [3];
    logic                    jump;

    assign s_in[0] = s_sample_x;
    assign s_in[1] = s_sample_y;
    assign s_in[2] = s_sample_z;

    always_comb begin
        logic signed [SMP_W:0] d;
        logic [SMP_W:0]        d_abs;
        jump = 1'b0;
        for (int a = 0; a < 3; a++) begin
            d     = (SMP_W + 1)'(s_in[a]) - (SMP_W + 1)'(prev_raw_reg[a]);
            d_abs = d[SMP_W] ? -d : d;
            if (d_abs > {1'b0, jump_thr_reg}) begin
                jump = 1'b1;
            end
        end
    end

    // -------------------------------------------------------------------
    // Per-axis prediction: P + Q (saturated), denominator and dividend
    // -------------------------------------------------------------------
    logic [COV_W:0]     p_sum;
    logic [COV_W-1:0]   p_sat;
    logic [DEN_W-1:0]   den;
    logic [NUM_W-1:0]   num;

    assign p_sum = {1'b0, cov_reg[axis_reg]} + {1'b0, proc_noise_reg};
    assign p_sat = p_sum[COV_W] ? COV_MAX : p_sum[COV_W-1:0];
    assign den   = {1'b0, p_sat} + {1'b0, meas_noise_reg};
    assign num   = (NUM_W'(p_sat) << FRAC_BITS) + NUM_W'(den >> 1);

    logic              div_start;
    logic              div_done;
    logic [QUOT_W-1:0] div_quot;

    assign div_start = (state_reg == ST_PREP);

    tkf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num),
        .den     (den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // -------------------------------------------------------------------
    // Shared multiplier: K*(m - X) in MUL1, P*(ONE - K) in EST
    // -------------------------------------------------------------------
    logic signed [DIFF_W-1:0] raw_q;
    logic signed [DIFF_W-1:0] innov;
    logic [QUOT_W-1:0]        one_minus_k;
    logic signed [DIFF_W-1:0] mul_a;
    logic signed [KB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod;

    assign raw_q       = DIFF_W'(raw_reg[axis_reg]) <<< FRAC_BITS;
    assign innov       = raw_q - DIFF_W'(est_reg[axis_reg]);
    assign one_minus_k = ONE_Q - k_reg;

    always_comb begin
        if (state_reg == ST_MUL1) begin
            mul_a = innov;
            mul_b = KB_W'(k_reg);
        end else begin
            mul_a = DIFF_W'(p_reg);
            mul_b = KB_W'(one_minus_k);
        end
    end

    tkf_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // Estimate update: round half away from zero, add, saturate
    logic                    prod_neg;
    logic [PROD_W-1:0]       prod_mag;
    logic [PROD_W-1:0]       rnd_full;
    logic signed [RND_W-1:0] rnd_mag;
    logic signed [RND_W-1:0] rnd;
    logic signed [SUM_W-1:0] x_sum;
    logic signed [EST_W-1:0] x_new;

    assign prod_neg = prod[PROD_W-1];
    assign prod_mag = prod_neg ? PROD_W'(-prod) : PROD_W'(prod);
    assign rnd_full = (prod_mag + HALF_P) >> FRAC_BITS;
    assign rnd_mag  = rnd_full[RND_W-1:0];
    assign rnd      = prod_neg ? -rnd_mag : rnd_mag;
    assign x_sum    = SUM_W'(rnd) + SUM_W'(est_reg[axis_reg]);

    always_comb begin
        if (x_sum > X_MAX) begin
            x_new = X_MAX[EST_W-1:0];
        end else if (x_sum < X_MIN) begin
            x_new = X_MIN[EST_W-1:0];
        end else begin
            x_new = x_sum[EST_W-1:0];
        end
    end

    // Covariance update: product is never negative here
    logic [PROD_W-1:0] cov_full;
    logic [COV_W-1:0]  cov_new;

    assign cov_full = (PROD_W'(prod) + HALF_P) >> FRAC_BITS;
    assign cov_new  = (cov_full > PROD_W'(COV_MAX)) ? COV_MAX : cov_full[COV_W-1:0];

    // -------------------------------------------------------------------
    // Direction from smoothed x and y (raw on a bypassed word), truncated toward zero
    // -------------------------------------------------------------------
    function automatic logic signed [INT_W-1:0] trunc_int(input logic signed [EST_W-1:0] v);
        logic [EST_W:0] mag;
        logic [EST_W:0] sh;
        mag = v[EST_W-1] ? (EST_W + 1)'(-(EST_W + 1)'(v)) : (EST_W + 1)'(v);
        sh  = mag >> FRAC_BITS;
        return v[EST_W-1] ? -INT_W'(sh) : INT_W'(sh);
    endfunction

    function automatic logic [OUT_W-1:0] to_out(input logic signed [EST_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return w[OUT_W-1:0];
    endfunction

    logic signed [INT_W-1:0] xi;
    logic signed [INT_W-1:0] yi;
    logic signed [INT_W-1:0] turn_pos;
    logic signed [INT_W-1:0] turn_neg;
    dir_t                    dir;

    assign xi       = trunc_int(smooth_reg[0]);
    assign yi       = trunc_int(smooth_reg[1]);
    assign turn_pos = INT_W'(turn_thr_reg);
    assign turn_neg = -turn_pos;

    // Priority: forward, backward, right, left, else stop
    always_comb begin
        if (yi > INT_W'(fwd_thr_reg)) begin
            dir = DIR_FORWARD;
        end else if (yi < INT_W'(bwd_thr_reg)) begin
            dir = DIR_BACKWARD;
        end else if (xi > turn_pos) begin
            dir = DIR_RIGHT;
        end else if (xi < turn_neg) begin
            dir = DIR_LEFT;
        end else begin
            dir = DIR_STOP;
        end
    end

    // -------------------------------------------------------------------
    // Handshakes
    // -------------------------------------------------------------------
    logic s_fire;
    logic out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Configuration writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meas_noise_reg <= MEAS_NOISE_RST;
            proc_noise_reg <= PROC_NOISE_RST;
            jump_thr_reg   <= JTH_W'(5);
            fwd_thr_reg    <= DTH_W'(4);
            bwd_thr_reg    <= -DTH_W'(4);
            turn_thr_reg   <= TTH_W'(3);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MEAS_NOISE:    meas_noise_reg <= COV_W'(cfg_wr_data);
                REG_PROCESS_NOISE: proc_noise_reg <= COV_W'(cfg_wr_data);
                REG_JUMP_THRESH:   jump_thr_reg   <= cfg_wr_data[JTH_W-1:0];
                REG_FWD_THRESH:    fwd_thr_reg    <= cfg_wr_data[DTH_W-1:0];
                REG_BWD_THRESH:    bwd_thr_reg    <= cfg_wr_data[DTH_W-1:0];
                REG_TURN_THRESH:   turn_thr_reg   <= cfg_wr_data[TTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            axis_reg        <= '0;
            jump_reg        <= 1'b0;
            last_dir_reg    <= DIR_FORWARD;
            est_reg[0]      <= '0;
            est_reg[1]      <= '0;
            est_reg[2]      <= EST_NINE;
            cov_reg[0]      <= COV_ONE;
            cov_reg[1]      <= COV_ONE;
            cov_reg[2]      <= COV_ONE;
            prev_raw_reg[0] <= '0;
            prev_raw_reg[1] <= '0;
            prev_raw_reg[2] <= SMP_W'(9);
            smooth_reg[0]   <= '0;
            smooth_reg[1]   <= '0;
            smooth_reg[2]   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // drop the word once taken, unless a new one loads in this cycle
            if (m_valid_reg && m_ready && state_reg != ST_DIR) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        // capture word; bypass loads raw values and skips the filter
                        axis_reg <= '0;
                        jump_reg <= jump;
                        for (int a = 0; a < 3; a++) begin
                            raw_reg[a]      <= s_in[a];
                            prev_raw_reg[a] <= s_in[a];
                            if (jump) begin
                                smooth_reg[a] <= EST_W'(s_in[a]) <<< FRAC_BITS;
                            end
                        end
                        state_reg <= jump ? ST_DIR : ST_PREP;
                    end
                end
                ST_PREP: begin
                    p_reg        <= p_sat;
                    den_zero_reg <= (den == '0);
                    state_reg    <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        k_reg     <= den_zero_reg ? '0 : div_quot;
                        state_reg <= ST_MUL1;
                    end
                end
                ST_MUL1: begin
                    state_reg <= ST_EST;
                end
                ST_EST: begin
                    est_reg[axis_reg]    <= x_new;
                    smooth_reg[axis_reg] <= x_new;
                    state_reg            <= ST_COV;
                end
                ST_COV: begin
                    cov_reg[axis_reg] <= cov_new;
                    if (axis_reg == 2'd2) begin
                        state_reg <= ST_DIR;
                    end else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= ST_PREP;
                    end
                end
                ST_DIR: begin
                    // hold until the output register frees up
                    if (out_free) begin
                        out_x_reg    <= to_out(smooth_reg[0]);
                        out_y_reg    <= to_out(smooth_reg[1]);
                        out_z_reg    <= to_out(smooth_reg[2]);
                        out_byp_reg  <= jump_reg;
                        out_dir_reg  <= dir;
                        out_chg_reg  <= (dir != last_dir_reg);
                        last_dir_reg <= dir;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_smooth_x    = out_x_reg;
    assign m_smooth_y    = out_y_reg;
    assign m_smooth_z    = out_z_reg;
    assign m_bypassed    = out_byp_reg;
    assign m_heading_cmd = out_dir_reg;
    assign m_cmd_changed = out_chg_reg;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
    ap_div_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide step");

    ap_gain_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MUL1 |-> k_reg <= ONE_Q)
        else $error("Kalman gain above one");

    ap_bypass_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && jump) |=> state_reg == ST_DIR)
        else $error("bypassed word did not go straight to direction");

    ap_axis_range: assert property (@(posedge aclk) disable iff (!aresetn)
        axis_reg != 2'd3)
        else $error("axis counter out of range");

    ap_result_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIR && out_free) |=> m_valid_reg && state_reg == ST_IDLE)
        else $error("result not loaded into output register");

endmodule

[design/tkf_div.sv]
// Restoring divider, one quotient bit per cycle. Quotient must fit QUOT_W bits.
module tkf_div import tkf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    output logic              done,
    output logic [QUOT_W-1:0] quot
);

    logic [CNT_W-1:0]  cnt_reg;
    logic              done_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [QUOT_W-1:0] low_reg;
    logic [QUOT_W-1:0] quot_reg;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] trial_sub;
    logic           q_bit;

    assign trial     = {rem_reg, low_reg[QUOT_W-1]};
    assign trial_sub = trial - {1'b0, den_reg};
    assign q_bit     = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(QUOT_W);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= DEN_W'(num[NUM_W-1:QUOT_W]);
            low_reg  <= num[QUOT_W-1:0];
            den_reg  <= den;
            quot_reg <= '0;
        end else if (cnt_reg != '0) begin
            rem_reg  <= q_bit ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
            low_reg  <= {low_reg[QUOT_W-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], q_bit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[design/tkf_mul.sv]
// Shared signed multiplier, product registered.
module tkf_mul import tkf_pkg::*; (
    input  logic                     aclk,
    input  logic signed [DIFF_W-1:0] op_a,
    input  logic signed [KB_W-1:0]   op_b,
    output logic signed [PROD_W-1:0] prod
);

    logic signed [PROD_W-1:0] prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(op_a) * PROD_W'(op_b);
    end

    assign prod = prod_reg;

endmodule
